>>> design/mvcc_pkg.sv
// mvcc_pkg: shared constants, register indexes and corner table for the
// metaball voxel case classifier; no dependencies
package mvcc_pkg;

   // payload field widths
   localparam int INDEX_W = 4;
   localparam int POS_W   = 16;
   localparam int VOXEL_W = 7;
   localparam int CODE_W  = 8;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_BALL_COUNT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_SIZE  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_VOXEL_SIZE = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ISO_LEVEL  = 2'd3;

   // commands
   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

   // register widths and reset values
   localparam int BALL_COUNT_W = 5;
   localparam int GRID_SIZE_W  = 8;
   localparam int VOXEL_SIZE_W = 15;
   localparam int ISO_LEVEL_W  = 32;
   localparam logic [BALL_COUNT_W-1:0] BALL_COUNT_RST = 5'd4;
   localparam logic [GRID_SIZE_W-1:0]  GRID_SIZE_RST  = 8'd32;
   localparam logic [VOXEL_SIZE_W-1:0] VOXEL_SIZE_RST = 15'd1024;
   localparam logic [ISO_LEVEL_W-1:0]  ISO_LEVEL_RST  = 32'd6553600;

   // grid limit on the effective grid size
   localparam int MAX_GRID = 128;

   // arithmetic widths: grid point, world coordinate, squared distance
   localparam int GRID_W  = 8;
   localparam int WORLD_W = 24;
   localparam int DIFF_W  = 25;
   localparam int MAG_W   = 24;
   localparam int SQ_W    = 50;
   localparam int QUO_W   = 46;
   localparam int DIV_STEPS = QUO_W / 2;
   localparam int DIV_CNT_W = 5;
   localparam int ONE_Q14 = 16384;
   localparam logic [SQ_W-1:0] MIN_SQ_DIST = 50'd26844;
   localparam logic [QUO_W-1:0] DIVIDEND = 46'h1 << 44;

   // corner offsets, bit 0 x, bit 1 y, bit 2 z
   function automatic logic [2:0] corner_offset(input logic [2:0] k);
      logic [2:0] off;
      unique case (k)
         3'd0: off = 3'b000;
         3'd1: off = 3'b001;
         3'd2: off = 3'b101;
         3'd3: off = 3'b100;
         3'd4: off = 3'b010;
         3'd5: off = 3'b011;
         3'd6: off = 3'b111;
         3'd7: off = 3'b110;
         default: off = 3'b000;
      endcase
      return off;
   endfunction

endpackage

>>> design/mvcc_if.sv
// mvcc_if: request and response channel interfaces with valid/ready
// depends on mvcc_pkg
interface mvcc_req_if import mvcc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     command;
   logic [INDEX_W-1:0]       ball_index;
   logic signed [POS_W-1:0]  ball_pos_x;
   logic signed [POS_W-1:0]  ball_pos_y;
   logic signed [POS_W-1:0]  ball_pos_z;
   logic [VOXEL_W-1:0]       voxel_x;
   logic [VOXEL_W-1:0]       voxel_y;
   logic [VOXEL_W-1:0]       voxel_z;

   modport source (output valid, command, ball_index, ball_pos_x, ball_pos_y,
                   ball_pos_z, voxel_x, voxel_y, voxel_z, input ready);
   modport sink (input valid, command, ball_index, ball_pos_x, ball_pos_y,
                 ball_pos_z, voxel_x, voxel_y, voxel_z, output ready);
endinterface

interface mvcc_rsp_if import mvcc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] case_code;

   modport source (output valid, case_code, input ready);
   modport sink (input valid, case_code, output ready);
endinterface

>>> design/mvcc_ram.sv
// mvcc_ram: generic single-write, single-read RAM with registered read
// no dependencies
module mvcc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/metaball_voxel_case_classifier_unit.sv
// metaball_voxel_case_classifier_unit: ball table in RAM, per-corner field
// energy with a shared squarer and a 2-bit-per-cycle divider
// depends on mvcc_pkg, mvcc_if, mvcc_ram
//
//   channel   dir   handshake        payload
//   req_ch    in    valid/ready      command, ball_index, ball_pos_xyz, voxel_xyz
//   rsp_ch    out   valid/ready      case_code (one per classify)
//   csr_*     in    csr_we           csr_addr, csr_wdata
//
// a load writes the ball table directly; a classify walks the eight corners,
// each ball taking three squaring steps, a clamp, 23 divider steps and
// the accumulate; boundary corners skip the ball walk. reset restores register
// defaults and marks all table entries zero. a pending response does not stop
// new requests; only the final handoff waits for the output register.
module metaball_voxel_case_classifier_unit import mvcc_pkg::*; #(
   parameter int MAX_BALLS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   mvcc_req_if.sink              req_ch,
   mvcc_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
   localparam int NW = $clog2(MAX_BALLS + 1);
   localparam int ENTRY_W = 3 * POS_W;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CORNER = 4'd1;
   localparam logic [3:0] ST_SQX    = 4'd2;
   localparam logic [3:0] ST_SQY    = 4'd3;
   localparam logic [3:0] ST_SQZ    = 4'd4;
   localparam logic [3:0] ST_CLAMP  = 4'd5;
   localparam logic [3:0] ST_DIV    = 4'd6;
   localparam logic [3:0] ST_ACC    = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   // registers
   logic [3:0]                state_ff, state_in;
   logic [BALL_COUNT_W-1:0]   ball_count_ff;
   logic [GRID_SIZE_W-1:0]    grid_size_ff;
   logic [VOXEL_SIZE_W-1:0]   voxel_size_ff;
   logic [ISO_LEVEL_W-1:0]    iso_level_ff;
   logic [VOXEL_W-1:0]        vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic [2:0]                corner_ff, corner_in;
   logic [CODE_W-1:0]         code_ff, code_in;
   logic signed [WORLD_W-1:0] wx_ff, wx_in, wy_ff, wy_in, wz_ff, wz_in;
   logic [NW-1:0]             ball_ff, ball_in;
   logic [SQ_W-1:0]           sq_ff, sq_in;
   logic [SQ_W-1:0]           div_ff, div_in;
   logic [SQ_W-1:0]           rem_ff, rem_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   logic [QUO_W-1:0]          dvd_ff, dvd_in;
   logic [DIV_CNT_W-1:0]      div_cnt_ff, div_cnt_in;
   logic [ISO_LEVEL_W-1:0]    sum_ff, sum_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]         case_code_ff, case_code_in;
   logic [MAX_BALLS-1:0]      entry_valid_ff;
   logic                      rd_valid_ff;

   // ram ports
   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;

   // datapath temporaries
   logic [NW-1:0]             n_eff;
   logic [GRID_SIZE_W-1:0]    gs_eff;
   logic [2:0]                off;
   logic [GRID_W-1:0]         gx, gy, gz;
   logic                      boundary;
   logic                      req_fire, load_hit;
   logic [ENTRY_W-1:0]        pos_word;
   logic signed [WORLD_W-1:0] w_sel;
   logic signed [POS_W-1:0]   p_sel;
   logic signed [DIFF_W-1:0]  diff;
   logic [DIFF_W-1:0]         diff_abs;
   logic [MAG_W-1:0]          mag;
   logic [2*MAG_W-1:0]        square;
   logic [SQ_W:0]             r1, r2, r1s;
   logic                      ge1, ge2;
   logic [ISO_LEVEL_W-1:0]    term;
   logic [ISO_LEVEL_W:0]      sum_wide;
   logic                      bit_set;

   mvcc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BALLS)
   ) u_ball_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // effective limits
   assign n_eff  = (int'(ball_count_ff) < MAX_BALLS) ? NW'(ball_count_ff) : NW'(MAX_BALLS);
   assign gs_eff = (int'(grid_size_ff) < MAX_GRID) ? grid_size_ff
                                                    : GRID_SIZE_W'(MAX_GRID);

   // corner grid point and boundary test
   assign off = corner_offset(corner_ff);
   assign gx  = {1'b0, vx_ff} + GRID_W'(off[0]);
   assign gy  = {1'b0, vy_ff} + GRID_W'(off[1]);
   assign gz  = {1'b0, vz_ff} + GRID_W'(off[2]);
   assign boundary = (gx == '0) || (gy == '0) || (gz == '0) ||
                     (gx >= gs_eff) || (gy >= gs_eff) || (gz >= gs_eff);

   // load path writes the ball table directly
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign load_hit = req_fire && (req_ch.command == CMD_LOAD) &&
                     ((NW + INDEX_W)'(req_ch.ball_index) < (NW + INDEX_W)'(n_eff));
   assign wr_en   = load_hit;
   assign wr_addr = AW'((AW + INDEX_W)'(req_ch.ball_index));
   assign wr_data = {req_ch.ball_pos_z, req_ch.ball_pos_y, req_ch.ball_pos_x};

   // squarer: one axis a cycle; entries never written read as zero
   assign pos_word = rd_valid_ff ? rd_data : '0;
   always_comb begin
      case (state_ff)
         ST_SQY: begin
            w_sel = wy_ff;
            p_sel = $signed(pos_word[2*POS_W-1:POS_W]);
         end
         ST_SQZ: begin
            w_sel = wz_ff;
            p_sel = $signed(pos_word[3*POS_W-1:2*POS_W]);
         end
         default: begin
            w_sel = wx_ff;
            p_sel = $signed(pos_word[POS_W-1:0]);
         end
      endcase
   end
   assign diff     = DIFF_W'(w_sel) - DIFF_W'(p_sel);
   assign diff_abs = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
   assign mag      = diff_abs[MAG_W-1:0];
   assign square   = mag * mag;

   // two restoring divide steps per cycle
   always_comb begin
      r1  = {rem_ff, dvd_ff[QUO_W-1]};
      ge1 = (r1 >= {1'b0, div_ff});
      r1s = ge1 ? (r1 - {1'b0, div_ff}) : r1;
      r2  = {r1s[SQ_W-1:0], dvd_ff[QUO_W-2]};
      ge2 = (r2 >= {1'b0, div_ff});
   end

   // term and saturating sum
   assign term     = (quo_ff[QUO_W-1:ISO_LEVEL_W] != '0) ? '1 : quo_ff[ISO_LEVEL_W-1:0];
   assign sum_wide = {1'b0, sum_ff} + {1'b0, term};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      vz_in        = vz_ff;
      corner_in    = corner_ff;
      code_in      = code_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      wz_in        = wz_ff;
      ball_in      = ball_ff;
      sq_in        = sq_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvd_in       = dvd_ff;
      div_cnt_in   = div_cnt_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      case_code_in = case_code_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      bit_set      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_ch.command == CMD_CLASSIFY) begin
               vx_in     = req_ch.voxel_x;
               vy_in     = req_ch.voxel_y;
               vz_in     = req_ch.voxel_z;
               corner_in = '0;
               code_in   = '0;
               state_in  = ST_CORNER;
            end
         end
         ST_CORNER: begin
            if (boundary || n_eff == '0) begin
               // energy zero never exceeds the level
               if (corner_ff == 3'd7) begin
                  state_in = ST_DONE;
               end else begin
                  corner_in = corner_ff + 3'd1;
               end
            end else begin
               wx_in    = $signed(WORLD_W'(gx) * WORLD_W'(voxel_size_ff) - WORLD_W'(ONE_Q14));
               wy_in    = $signed(WORLD_W'(gy) * WORLD_W'(voxel_size_ff) - WORLD_W'(ONE_Q14));
               wz_in    = $signed(WORLD_W'(gz) * WORLD_W'(voxel_size_ff) - WORLD_W'(ONE_Q14));
               ball_in  = '0;
               sum_in   = '0;
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            sq_in    = SQ_W'(square);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sq_in    = sq_ff + SQ_W'(square);
            state_in = ST_SQZ;
         end
         ST_SQZ: begin
            sq_in    = sq_ff + SQ_W'(square);
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            div_in     = (sq_ff < MIN_SQ_DIST) ? MIN_SQ_DIST : sq_ff;
            rem_in     = '0;
            quo_in     = '0;
            dvd_in     = DIVIDEND;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            rem_in     = ge2 ? SQ_W'(r2 - {1'b0, div_ff}) : r2[SQ_W-1:0];
            quo_in     = {quo_ff[QUO_W-3:0], ge1, ge2};
            dvd_in     = {dvd_ff[QUO_W-3:0], 2'b00};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            sum_in = sum_wide[ISO_LEVEL_W] ? '1 : sum_wide[ISO_LEVEL_W-1:0];
            if (ball_ff + 1'b1 < n_eff) begin
               ball_in  = ball_ff + 1'b1;
               rd_en    = 1'b1;
               rd_addr  = AW'(ball_ff + 1'b1);
               state_in = ST_SQX;
            end else begin
               bit_set = (sum_in > iso_level_ff);
               code_in = code_ff | (CODE_W'(bit_set) << corner_ff);
               if (corner_ff == 3'd7) begin
                  state_in = ST_DONE;
               end else begin
                  corner_in = corner_ff + 3'd1;
                  state_in  = ST_CORNER;
               end
            end
         end
         ST_DONE: begin
            // hand off once the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               case_code_in = code_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
         ball_count_ff  <= BALL_COUNT_RST;
         grid_size_ff   <= GRID_SIZE_RST;
         voxel_size_ff  <= VOXEL_SIZE_RST;
         iso_level_ff   <= ISO_LEVEL_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            entry_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= entry_valid_ff[rd_addr];
         end
         if (csr_we) begin
            unique case (csr_addr)
               CSR_BALL_COUNT: ball_count_ff <= csr_wdata[BALL_COUNT_W-1:0];
               CSR_GRID_SIZE:  grid_size_ff  <= csr_wdata[GRID_SIZE_W-1:0];
               CSR_VOXEL_SIZE: voxel_size_ff <= csr_wdata[VOXEL_SIZE_W-1:0];
               CSR_ISO_LEVEL:  iso_level_ff  <= csr_wdata[ISO_LEVEL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      vz_ff        <= vz_in;
      corner_ff    <= corner_in;
      code_ff      <= code_in;
      wx_ff        <= wx_in;
      wy_ff        <= wy_in;
      wz_ff        <= wz_in;
      ball_ff      <= ball_in;
      sq_ff        <= sq_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dvd_ff       <= dvd_in;
      div_cnt_ff   <= div_cnt_in;
      sum_ff       <= sum_in;
      case_code_ff <= case_code_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.case_code = case_code_ff;

   // the ball walk never passes the active count
   a_ball_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQX) |-> (ball_ff < n_eff))
      else $error("ball counter beyond active count");

   // the divider finishes after its fixed step count
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) |=> (state_ff == ST_ACC))
      else $error("divider step count broken");

   // a new response only appears from the handoff state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response without finished classify");

   // the remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> (rem_ff < div_ff))
      else $error("divider remainder out of range");

endmodule
